@@ hdl/radix_digit_converter_top_macros.svh @@
// Assertion macros used by the top level of the radix digit converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of clock, suspended while reset is high.
`define RDC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every rising edge of clock, including during reset.
`define RDC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define RDC_ASSERT(lbl, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/rdc_pkg.sv @@
// Types, constants and helper functions of the radix digit converter.
`timescale 1ns / 1ps
package rdc_pkg;

   localparam int VALUE_WIDTH_DEF = 31;
   localparam int BASE_W          = 5;
   localparam int DIGIT_W         = 4;
   localparam int CHAR_W          = 7;

   localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
   localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;

   localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 4'd10;
   localparam logic [CHAR_W-1:0]  ZERO_CHAR      = 7'd48;
   localparam logic [CHAR_W-1:0]  LETTER_FIRST   = 7'd65;
   localparam logic [CHAR_W-1:0]  NINE_CHAR      = 7'd57;
   localparam logic [CHAR_W-1:0]  LETTER_LAST    = 7'd70;
   localparam logic [CHAR_W-1:0]  LETTER_OFFSET  = LETTER_FIRST - CHAR_W'(DECIMAL_DIGITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_POP,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic load;
      logic next;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic nonzero;
   } div_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

   // Radix values outside 2..16 are clamped to the nearest legal radix.
   function automatic logic [BASE_W-1:0] effective_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      r = b;
      if (b < BASE_MIN) begin
         r = BASE_MIN;
      end else if (b > BASE_MAX) begin
         r = BASE_MAX;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d >= DECIMAL_DIGITS) begin
         c = CHAR_W'(d) + LETTER_OFFSET;
      end else begin
         c = CHAR_W'(d) + ZERO_CHAR;
      end
      return c;
   endfunction

endpackage

@@ hdl/rdc_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle by a narrow radix.
`timescale 1ns / 1ps
module rdc_divider
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  div_ctrl_type           ctrl,
   input  logic [VALUE_WIDTH-1:0] value,
   input  logic [BASE_W-1:0]      base,
   output div_status_type         status,
   output logic [DIGIT_W-1:0]     remainder
);

   localparam int CNT_W = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic                   nz_ff, nz_in;
   logic [DIGIT_W:0]       rem_shift;
   logic                   q_bit;

   // The partial remainder stays below the radix, so a 5-bit compare suffices.
   assign rem_shift = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign q_bit     = (rem_shift >= base);

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      nz_in   = nz_ff;
      if (ctrl.load || ctrl.next) begin
         // On next, the quotient just produced is divided again in place.
         if (ctrl.load) begin
            quot_in = value;
         end
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         nz_in   = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], q_bit};
         if (q_bit) begin
            rem_in = DIGIT_W'(rem_shift - base);
         end else begin
            rem_in = rem_shift[DIGIT_W-1:0];
         end
         nz_in  = nz_ff | q_bit;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      nz_ff   <= nz_in;
   end

   assign status.busy    = busy_ff;
   assign status.done    = done_ff;
   assign status.nonzero = nz_ff;
   assign remainder      = rem_ff;

endmodule

@@ hdl/rdc_digit_stack.sv @@
// Digit stack: remainders pushed least significant first, popped as ASCII.
`timescale 1ns / 1ps
module rdc_digit_stack
   import rdc_pkg::*;
#(
   parameter int DEPTH = VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stack_ctrl_type             ctrl,
   input  logic [DIGIT_W-1:0]         push_digit,
   output logic [CHAR_W-1:0]          rd_char,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);

   logic [DIGIT_W-1:0] mem [DEPTH];
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      count_dec;
   logic [CHAR_W-1:0]  rd_char_ff;

   assign count_dec = count_ff - CW'(1);

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[count_ff[AW-1:0]] <= push_digit;
      end
   end

   // The popped entry comes out registered, already turned into its character.
   always_ff @(posedge clock) begin
      if (ctrl.pop) begin
         rd_char_ff <= digit_to_char(mem[count_dec[AW-1:0]]);
      end
   end

   assign rd_char = rd_char_ff;
   assign count   = count_ff;

endmodule

@@ hdl/radix_digit_converter_top.sv @@
// Top level of the radix digit converter: control sequencer and output register.
//
// Use: each request transaction carries one unsigned value on req_value. The
// block converts it to digits in the radix held in the csr register (2..16,
// clamped, reset 10) and returns one response transaction per digit, most
// significant first, as an ASCII code on rsp_digit_char; rsp_last marks the
// final, least significant digit. A value of zero yields the single digit '0'.
// Write the radix with csr_wr_en/csr_wr_data only while no conversion is open.
// Timing: every digit costs one pass of the bit-serial divider, one quotient
// bit per cycle. req_ready is high only between items; the next item is
// accepted while the last digit of the previous one still waits in the output
// register. When the receiver holds rsp_ready low the response and the
// sequencer wait; nothing is dropped. Reset (synchronous, active high) empties
// the block and restores radix 10.
`timescale 1ns / 1ps
`include "radix_digit_converter_top_macros.svh"
module radix_digit_converter_top
   import rdc_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_W-1:0]      rsp_digit_char,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic [BASE_W-1:0]      csr_wr_data
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   state_type          state_ff, state_in;
   logic [BASE_W-1:0]  base_ff;
   logic [BASE_W-1:0]  base_eff;
   div_ctrl_type       div_ctrl;
   div_status_type     div_status;
   logic [DIGIT_W-1:0] div_rem;
   stack_ctrl_type     stack_ctrl;
   logic [CHAR_W-1:0]  stack_char;
   logic [CW-1:0]      stack_count;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  rsp_char_ff;
   logic               rsp_last_ff;
   logic               rsp_load;
   logic               out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
      end else if (csr_wr_en) begin
         base_ff <= csr_wr_data;
      end
   end

   assign base_eff = effective_base(base_ff);

   rdc_divider #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .value    (req_value),
      .base     (base_eff),
      .status   (div_status),
      .remainder(div_rem)
   );

   rdc_digit_stack #(
      .DEPTH(VALUE_WIDTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (stack_ctrl),
      .push_digit(div_rem),
      .rd_char   (stack_char),
      .count     (stack_count)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      div_ctrl.load   = 1'b0;
      div_ctrl.next   = 1'b0;
      stack_ctrl.push = 1'b0;
      stack_ctrl.pop  = 1'b0;
      rsp_load        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_ctrl.load = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               stack_ctrl.push = 1'b1;
               if (div_status.nonzero) begin
                  div_ctrl.next = 1'b1;
               end else begin
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            stack_ctrl.pop = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            // A further pop overlaps the load, giving one digit per cycle here while the output register is free.
            if (out_free) begin
               rsp_load = 1'b1;
               if (stack_count == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  stack_ctrl.pop = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_char_ff <= stack_char;
         rsp_last_ff <= (stack_count == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

   `RDC_ASSERT(a_idle_div_quiet, (state_ff == ST_IDLE) |-> !div_status.busy,
               "divider busy while idle")
   `RDC_ASSERT(a_push_room, stack_ctrl.push |-> (stack_count < CW'(VALUE_WIDTH)),
               "digit stack overflow")
   `RDC_ASSERT(a_pop_nonempty, stack_ctrl.pop |-> (stack_count != '0),
               "pop from empty digit stack")
   `RDC_ASSERT(a_char_range,
               rsp_valid |-> ((rsp_digit_char >= ZERO_CHAR && rsp_digit_char <= NINE_CHAR) ||
                  (rsp_digit_char >= LETTER_FIRST && rsp_digit_char <= LETTER_LAST)),
               "response is not a digit character")
   `RDC_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_valid && state_ff == ST_IDLE),
                      "reset did not clear the block")

endmodule

@@ tb/radix_digit_converter_top_test.sv @@
// Self-checking testbench for the radix digit converter over many radixes.
`timescale 1ns / 1ps
module radix_digit_converter_top_test;
   import rdc_pkg::*;

   localparam int VW             = VALUE_WIDTH_DEF;
   localparam int SETTLE_CYCLES  = VW + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 62;
   localparam int ITEMS_PER_BASE = 16;

   typedef struct packed {
      logic [CHAR_W-1:0] digit_char;
      logic              last;
   } digit_result_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   logic [VW-1:0]     req_value   = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic              rsp_last;
   logic              csr_wr_en   = 1'b0;
   logic [BASE_W-1:0] csr_wr_data = '0;

   // Radix as the block should currently hold it.
   logic [BASE_W-1:0] base_reg = BASE_RESET;
   digit_result_type  expected_digits[$];
   int                errors         = 0;
   int                stall_cycles   = 0;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;

   radix_digit_converter_top #(.VALUE_WIDTH(VW)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Divide by the clamped radix, then queue the digits most significant first.
   task automatic record_expected(input logic [VW-1:0] v);
      logic [VW-1:0]      q;
      logic [DIGIT_W-1:0] stack [VW];
      logic [DIGIT_W-1:0] d;
      int unsigned        radix;
      int                 n;
      digit_result_type   r;
      radix = base_reg;
      if (radix < BASE_MIN) begin
         radix = BASE_MIN;
      end else if (radix > BASE_MAX) begin
         radix = BASE_MAX;
      end
      q = v;
      n = 0;
      do begin
         stack[n] = DIGIT_W'(q % radix);
         n++;
         q = VW'(q / radix);
      end while (q != 0);
      for (int k = n - 1; k >= 0; k--) begin
         d = stack[k];
         if (d < DECIMAL_DIGITS) begin
            r.digit_char = ZERO_CHAR + CHAR_W'(d);
         end else begin
            r.digit_char = LETTER_FIRST + CHAR_W'(d - DECIMAL_DIGITS);
         end
         r.last = (k == 0);
         expected_digits.push_back(r);
      end
   endtask

   // Valid is only lowered when a gap is taken, so back-to-back items keep it high.
   task automatic send_value(input logic [VW-1:0] v);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      record_expected(v);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_base(input logic [BASE_W-1:0] b);
      wait_for_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= b;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_reg  = b;
      @(posedge clock);
   endtask

   function automatic logic [VW-1:0] random_value();
      logic [VW-1:0] v;
      int            pick;
      pick = $urandom_range(9);
      v    = VW'($urandom);
      if (pick == 0) begin
         v = '0;
      end else if (pick == 1) begin
         v = '1;
      end else if (pick < 7) begin
         // A random right shift gives shorter values and so conversions with fewer digits.
         v = v >> $urandom_range(VW - 1);
      end
      return v;
   endfunction

   function automatic logic [BASE_W-1:0] random_base();
      if ($urandom_range(9) == 0) begin
         return BASE_W'($urandom_range(31));
      end
      return BASE_W'($urandom_range(16, 2));
   endfunction

   task automatic test_decimal_reset_base();
      send_value('0);
      send_value(VW'(1));
      send_value(VW'(9));
      send_value(VW'(10));
      send_value('1);
      send_value(VW'(1000000000));
   endtask

   task automatic test_base_limits();
      write_base(BASE_MAX);
      send_value(VW'(32'h7FED_CBA9));
      send_value(VW'(15));
      send_value(VW'(16));
      write_base(BASE_MIN);
      send_value('1);
      send_value(VW'(32'h2AAA_AAAA));
      send_value(VW'(1));
      // Radixes below two and above sixteen are clamped.
      write_base(5'd0);
      send_value(VW'(5));
      write_base(5'd1);
      send_value(VW'(6));
      write_base(5'd17);
      send_value(VW'(255));
      write_base(5'd31);
      send_value(VW'(32'h7ABC_DEF1));
      write_base(5'd3);
      send_value('1);
      write_base(5'd9);
      send_value(VW'(80));
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (i % ITEMS_PER_BASE == 0) begin
            write_base(random_base());
         end
         send_value(random_value());
      end
   endtask

   always @(posedge clock) begin : digit_checker
      digit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit transaction: digit_char=%0d last=%0b",
                     $time, rsp_digit_char, rsp_last);
            errors++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_digit_char !== want.digit_char) begin
               $display("%0t: digit_char expected %0d actual %0d",
                        $time, want.digit_char, rsp_digit_char);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Ends the run when no transaction has moved on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("radix_digit_converter_top: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_decimal_reset_base();
      test_base_limits();
      test_random_traffic(0, 0);
      test_random_traffic(67, 0);
      test_random_traffic(0, 67);
      test_random_traffic(9, 9);
      wait_for_idle();
      if (errors == 0) begin
         $display("radix_digit_converter_top: match");
      end else begin
         $display("radix_digit_converter_top: mismatch");
      end
      $finish;
   end

endmodule
